>>> rtl/cms_pkg.sv
package cms_pkg;

    localparam int TIME_BITS = 32;
    typedef logic [TIME_BITS-1:0] t_time;

    localparam int unsigned CHECK_WAIT_MS   = 50;
    localparam int unsigned SETTLE_MS       = 500;
    localparam int unsigned RAMP_MS         = 2000;
    localparam int unsigned RAMP_TIMEOUT_MS = 15000;
    localparam logic signed [15:0] CONTACT_SPEED = 16'sd128;

    // ramp divide: x / 2000 = ((x >> 4) * RECIP_MULT) >> RECIP_SHIFT, exact for x < 2^26
    localparam int RAMP_EL_W   = 11;
    localparam int HOLD_W      = 15;
    localparam int PROD_W      = HOLD_W + RAMP_EL_W;
    localparam int PRE_SHIFT   = 4;
    localparam int QUOT_IN_W   = PROD_W - PRE_SHIFT;
    localparam int RECIP_SHIFT = 29;
    localparam int RECIP_W     = 23;
    localparam int unsigned RECIP_MULT_I = ((1 << RECIP_SHIFT) + 124) / 125;
    localparam logic [RECIP_W-1:0] RECIP_MULT = RECIP_W'(RECIP_MULT_I);
    localparam int RECIP_PROD_W = QUOT_IN_W + RECIP_W;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_POLL  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CMD_NONE   = 3'd0,
        CMD_LIMITS = 3'd1,
        CMD_VEL    = 3'd2,
        CMD_RAISE  = 3'd3,
        CMD_TORQUE = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        CFG_MODE      = 3'd0,
        CFG_GAP       = 3'd1,
        CFG_SPEED     = 3'd2,
        CFG_HOLD      = 3'd3,
        CFG_TRAVEL_TO = 3'd4,
        CFG_VLIM      = 3'd5,
        CFG_CUR_INIT  = 3'd6,
        CFG_CUR_CONT  = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        PH_CHECK  = 4'b0001,
        PH_TRAVEL = 4'b0010,
        PH_RAMP   = 4'b0100,
        PH_DONE   = 4'b1000
    } t_phase;

    typedef struct packed {
        t_cmd        cmd;
        logic [15:0] value_a;
        logic [15:0] value_b;
        logic        ramp;
    } t_slot;

    typedef struct packed {
        t_slot [3:0]       slot;
        logic [1:0]        last_idx;
        logic              fin;
        logic              timed_out;
        logic              complete_ok;
        logic [PROD_W-1:0] prod;
    } t_item;

endpackage

>>> rtl/cms_if.sv
interface cms_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [31:0]        now_ms;
    logic signed [15:0] velocity;
    logic               axis_error;

    modport source (output valid, operation, now_ms, velocity, axis_error, input ready);
    modport sink   (input valid, operation, now_ms, velocity, axis_error, output ready);
endinterface

interface cms_res_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic signed [15:0] value_a;
    logic [15:0]        value_b;
    logic               finished;
    logic               timed_out;
    logic               complete_ok;
    logic               last;

    modport source (output valid, command, value_a, value_b, finished, timed_out,
                    complete_ok, last, input ready);
    modport sink   (input valid, command, value_a, value_b, finished, timed_out,
                    complete_ok, last, output ready);
endinterface

>>> rtl/cms_core.sv
module cms_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_take,
    input  logic [1:0]         i_operation,
    input  logic [31:0]        i_now_ms,
    input  logic signed [15:0] i_velocity,
    input  logic               i_axis_error,
    output cms_pkg::t_item     o_item
);

    logic        r_mode;
    logic [9:0]  r_gap;
    logic [14:0] r_speed;
    logic [14:0] r_hold;
    logic [15:0] r_travel_to;
    logic [14:0] r_vlim;
    logic [15:0] r_cur_init;
    logic [15:0] r_cur_cont;

    cms_pkg::t_phase r_phase, n_phase;
    logic            r_entry, n_entry;
    cms_pkg::t_time  r_start, n_start;
    cms_pkg::t_time  r_last_cmd, n_last_cmd;
    logic            r_cflag, n_cflag;
    logic            r_tflag, n_tflag;

    cms_pkg::t_time  now;
    cms_pkg::t_time  el;
    logic            gap_ok;
    logic            settle;
    logic            contact;
    logic            ramp_sat;
    logic            fin;
    logic [3:0]      cand_v;
    cms_pkg::t_slot  cand [4];
    cms_pkg::t_slot  none_slot;
    logic [2:0]      cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_gap       <= 10'd10;
            r_speed     <= 15'd256;
            r_hold      <= 15'd256;
            r_travel_to <= 16'd10000;
            r_vlim      <= 15'd1280;
            r_cur_init  <= 16'd1280;
            r_cur_cont  <= 16'd2560;
        end else if (i_cfg_we) begin
            unique case (cms_pkg::t_cfg_idx'(i_cfg_idx))
                cms_pkg::CFG_MODE:      r_mode      <= i_cfg_data[0];
                cms_pkg::CFG_GAP:       r_gap       <= i_cfg_data[9:0];
                cms_pkg::CFG_SPEED:     r_speed     <= i_cfg_data[14:0];
                cms_pkg::CFG_HOLD:      r_hold      <= i_cfg_data[14:0];
                cms_pkg::CFG_TRAVEL_TO: r_travel_to <= i_cfg_data;
                cms_pkg::CFG_VLIM:      r_vlim      <= i_cfg_data[14:0];
                cms_pkg::CFG_CUR_INIT:  r_cur_init  <= i_cfg_data;
                cms_pkg::CFG_CUR_CONT:  r_cur_cont  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= cms_pkg::PH_DONE;
            r_entry    <= 1'b0;
            r_start    <= '0;
            r_last_cmd <= '0;
            r_cflag    <= 1'b0;
            r_tflag    <= 1'b0;
        end else if (i_take) begin
            r_phase    <= n_phase;
            r_entry    <= n_entry;
            r_start    <= n_start;
            r_last_cmd <= n_last_cmd;
            r_cflag    <= n_cflag;
            r_tflag    <= n_tflag;
        end
    end

    assign now      = cms_pkg::t_time'(i_now_ms);
    assign el       = now - r_start;
    assign gap_ok   = (now - r_last_cmd) >= cms_pkg::t_time'(r_gap);
    assign settle   = el > cms_pkg::t_time'(cms_pkg::SETTLE_MS);
    assign contact  = (i_velocity < cms_pkg::CONTACT_SPEED) &&
                      (i_velocity > -cms_pkg::CONTACT_SPEED);
    assign ramp_sat = el >= cms_pkg::t_time'(cms_pkg::RAMP_MS);

    always_comb begin
        n_phase    = r_phase;
        n_entry    = r_entry;
        n_start    = r_start;
        n_last_cmd = r_last_cmd;
        n_cflag    = r_cflag;
        n_tflag    = r_tflag;
        fin        = 1'b0;
        cand_v     = '0;
        for (int k = 0; k < 4; k++) begin
            cand[k] = '{cmd: cms_pkg::CMD_NONE, value_a: '0, value_b: '0, ramp: 1'b0};
        end
        case (cms_pkg::t_op'(i_operation))
            cms_pkg::OP_START: begin
                n_entry    = 1'b1;
                n_start    = now;
                n_last_cmd = now;
                n_cflag    = 1'b0;
                n_tflag    = 1'b0;
                n_phase    = r_mode ? cms_pkg::PH_RAMP : cms_pkg::PH_CHECK;
            end
            cms_pkg::OP_CLEAR: begin
                n_entry = 1'b1;
                n_cflag = 1'b0;
                n_tflag = 1'b0;
            end
            cms_pkg::OP_POLL: begin
                unique case (r_phase)
                    cms_pkg::PH_CHECK: begin
                        n_entry = 1'b0;
                        if (el > cms_pkg::t_time'(cms_pkg::CHECK_WAIT_MS)) begin
                            n_phase = cms_pkg::PH_TRAVEL;
                            n_start = now;
                            n_entry = 1'b1;
                        end
                    end
                    cms_pkg::PH_TRAVEL: begin
                        cand_v[0] = r_entry;
                        cand[0]   = '{cmd: cms_pkg::CMD_LIMITS, value_a: {1'b0, r_vlim},
                                      value_b: r_cur_init, ramp: 1'b0};
                        n_entry   = 1'b0;
                        cand_v[1] = gap_ok;
                        cand[1]   = '{cmd: cms_pkg::CMD_VEL, value_a: {1'b0, r_speed},
                                      value_b: '0, ramp: 1'b0};
                        if (gap_ok) begin
                            n_last_cmd = now;
                        end
                        cand[2] = '{cmd: cms_pkg::CMD_VEL, value_a: '0, value_b: '0,
                                    ramp: 1'b0};
                        cand[3] = '{cmd: cms_pkg::CMD_RAISE, value_a: '0,
                                    value_b: r_cur_cont, ramp: 1'b0};
                        if (settle && (contact || i_axis_error)) begin
                            cand_v[2]  = 1'b1;
                            cand_v[3]  = 1'b1;
                            n_last_cmd = now;
                            n_phase    = cms_pkg::PH_RAMP;
                            n_start    = now;
                            n_entry    = 1'b1;
                        end else if (el > cms_pkg::t_time'(r_travel_to)) begin
                            cand_v[2]  = 1'b1;
                            n_tflag    = 1'b1;
                            n_cflag    = 1'b1;
                            n_last_cmd = now;
                            n_phase    = cms_pkg::PH_DONE;
                            n_entry    = 1'b1;
                            fin        = 1'b1;
                        end
                    end
                    cms_pkg::PH_RAMP: begin
                        cand_v[0] = r_entry && r_mode;
                        cand[0]   = '{cmd: cms_pkg::CMD_LIMITS, value_a: {1'b0, r_vlim},
                                      value_b: r_cur_init, ramp: 1'b0};
                        n_entry   = 1'b0;
                        cand_v[1] = gap_ok;
                        cand[1]   = '{cmd: cms_pkg::CMD_TORQUE,
                                      value_a: ramp_sat ? {1'b0, r_hold} : 16'd0,
                                      value_b: '0, ramp: !ramp_sat};
                        if (gap_ok) begin
                            n_last_cmd = now;
                        end
                        cand[2] = '{cmd: cms_pkg::CMD_TORQUE, value_a: '0, value_b: '0,
                                    ramp: 1'b0};
                        if (((ramp_sat || r_hold == '0) && settle) ||
                            (settle && i_axis_error) ||
                            el > cms_pkg::t_time'(cms_pkg::RAMP_TIMEOUT_MS)) begin
                            cand_v[2]  = 1'b1;
                            n_last_cmd = now;
                            n_cflag    = 1'b1;
                            n_phase    = cms_pkg::PH_DONE;
                            n_entry    = 1'b1;
                            fin        = 1'b1;
                        end
                    end
                    cms_pkg::PH_DONE: ;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_comb begin
        none_slot = '{cmd: cms_pkg::CMD_NONE, value_a: '0, value_b: '0, ramp: 1'b0};
        cnt       = '0;
        for (int k = 0; k < 4; k++) begin
            o_item.slot[k] = none_slot;
        end
        for (int k = 0; k < 4; k++) begin
            if (cand_v[k]) begin
                o_item.slot[cnt[1:0]] = cand[k];
                cnt = cnt + 3'd1;
            end
        end
        o_item.last_idx    = (cnt == '0) ? 2'd0 : 2'(cnt - 3'd1);
        o_item.fin         = fin;
        o_item.timed_out   = n_tflag;
        o_item.complete_ok = n_cflag && !n_tflag;
        o_item.prod        = {{cms_pkg::RAMP_EL_W{1'b0}}, r_hold} *
                             {{cms_pkg::HOLD_W{1'b0}}, el[cms_pkg::RAMP_EL_W-1:0]};
    end

endmodule

>>> rtl/cms_out.sv
module cms_out (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  cms_pkg::t_item i_item,
    output logic           o_can_load,
    cms_res_if.source      o_res
);

    logic           r_busy;
    logic [1:0]     r_idx;
    cms_pkg::t_item r_item;

    cms_pkg::t_slot                           cur;
    logic                                     is_last;
    logic [cms_pkg::QUOT_IN_W-1:0]            quot_in;
    logic [cms_pkg::RECIP_PROD_W-1:0]         recip_prod;
    logic [cms_pkg::HOLD_W-1:0]               target;

    assign cur     = r_item.slot[r_idx];
    assign is_last = r_idx == r_item.last_idx;

    // torque ramp target: product / 2000
    assign quot_in    = r_item.prod[cms_pkg::PROD_W-1:cms_pkg::PRE_SHIFT];
    assign recip_prod = {{cms_pkg::RECIP_W{1'b0}}, quot_in} *
                        {{cms_pkg::QUOT_IN_W{1'b0}}, cms_pkg::RECIP_MULT};
    assign target     = recip_prod[cms_pkg::RECIP_SHIFT +: cms_pkg::HOLD_W];

    assign o_can_load = !r_busy || (o_res.ready && is_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy && o_res.ready) begin
            if (is_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_res.valid       = r_busy;
    assign o_res.command     = cur.cmd;
    assign o_res.value_a     = cur.ramp ? {1'b0, target} : cur.value_a;
    assign o_res.value_b     = cur.value_b;
    assign o_res.finished    = r_item.fin;
    assign o_res.timed_out   = r_item.timed_out;
    assign o_res.complete_ok = r_item.complete_ok;
    assign o_res.last        = is_last;

endmodule

>>> rtl/compression_motor_sequencer_unit.sv
// Compression motor sequencer.
// Requests arrive on i_req (operation, now_ms, velocity, axis_error) with a
// valid/ready handshake; results leave on o_res, one per motor command, with
// last marking the final result of a request. A request that issues no
// command gives a single result with command none.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx; write
// only while no request is in flight. The first result of a request is
// valid the cycle after it is accepted. Throughput: one request per cycle
// while each gives one result and the receiver is ready; a request giving
// n results holds the output register until all n are taken, and the next
// request is taken in the cycle its last result is taken.
// The ramp torque is computed in the output stage from the product stored
// with the request.
// Reset (synchronous, active low) returns the registers to their defaults,
// the sequence to done with flags clear, and empties the output register.
// When the receiver stalls, the current result holds and i_req.ready stays
// low until the last result of the pending request is taken.
module compression_motor_sequencer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    cms_req_if.sink     i_req,
    cms_res_if.source   o_res
);

    logic           can_load;
    logic           take;
    cms_pkg::t_item item;

    assign i_req.ready = can_load;
    assign take        = i_req.valid && can_load;

    cms_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_take       (take),
        .i_operation  (i_req.operation),
        .i_now_ms     (i_req.now_ms),
        .i_velocity   (i_req.velocity),
        .i_axis_error (i_req.axis_error),
        .o_item       (item)
    );

    cms_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (take),
        .i_item     (item),
        .o_can_load (can_load),
        .o_res      (o_res)
    );

endmodule

>>> rtl/cms_checker.sv
module cms_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_command,
    input logic       i_finished,
    input logic       i_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> !i_out_valid || (i_out_ready && i_last))
        else $error("request accepted over pending results");

    a_more_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last |=> i_out_valid)
        else $error("request results cut short");

    a_finish_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_finished && i_last |->
            (i_command == cms_pkg::CMD_VEL || i_command == cms_pkg::CMD_TORQUE))
        else $error("finishing request does not end with a stop move");

endmodule

bind compression_motor_sequencer_unit cms_checker u_cms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_command   (o_res.command),
    .i_finished  (o_res.finished),
    .i_last      (o_res.last)
);

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int LIMIT_CYCLES   = 400000;
    localparam int MAX_REPORTS    = 50;
    localparam int SETTLE_CYCLES  = 4;

    typedef struct {
        cms_pkg::t_op       op;
        logic [31:0]        now_ms;
        logic signed [15:0] velocity;
        logic               axis_error;
        bit                 drain;
    } t_motor_req;

    typedef struct {
        cms_pkg::t_cmd cmd;
        logic [15:0]   value_a;
        logic [15:0]   value_b;
        logic          finished;
        logic          timed_out;
        logic          complete_ok;
        logic          last;
    } t_motor_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [15:0] cfg_data;

    cms_req_if req_ch();
    cms_res_if res_ch();

    compression_motor_sequencer_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_res      (res_ch)
    );

    always #5 i_clk = ~i_clk;

    // register copies
    logic        cfg_mode      = 1'b0;
    logic [9:0]  cfg_gap       = 10'd10;
    logic [14:0] cfg_speed     = 15'd256;
    logic [14:0] cfg_hold      = 15'd256;
    logic [15:0] cfg_travel_to = 16'd10000;
    logic [14:0] cfg_vlim      = 15'd1280;
    logic [15:0] cfg_cur_init  = 16'd1280;
    logic [15:0] cfg_cur_cont  = 16'd2560;

    // sequencer state
    cms_pkg::t_phase seq_phase      = cms_pkg::PH_DONE;
    logic            entry_pending  = 1'b0;
    logic [31:0]     phase_start_ms = '0;
    logic [31:0]     last_cmd_ms    = '0;
    logic            complete_flag  = 1'b0;
    logic            timeout_flag   = 1'b0;

    t_motor_req pending_reqs[$];
    t_motor_res expected_results[$];
    t_motor_req on_wire;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int reqs_queued        = 0;
    int reqs_taken         = 0;
    int starts_seen        = 0;
    int results_checked    = 0;
    int runs_ended         = 0;
    int timeouts_seen      = 0;
    int mismatches         = 0;
    int cycle_count        = 0;

    function automatic t_motor_res make_cmd(input cms_pkg::t_cmd c, input logic [15:0] a,
                                            input logic [15:0] b);
        t_motor_res r;
        r = '{cmd: c, value_a: a, value_b: b, finished: 1'b0, timed_out: 1'b0,
              complete_ok: 1'b0, last: 1'b0};
        return r;
    endfunction

    function automatic void advance_sequencer(input t_motor_req rq);
        logic [31:0] el;
        logic [16:0] vmag;
        logic [63:0] target;
        logic        fin;
        t_motor_res  burst[$];
        t_motor_res  one;
        fin = 1'b0;
        el = rq.now_ms - phase_start_ms;
        vmag = rq.velocity[15] ? 17'h10000 - {1'b0, rq.velocity} : {1'b0, rq.velocity};
        case (rq.op)
            cms_pkg::OP_START: begin
                entry_pending = 1'b1;
                phase_start_ms = rq.now_ms;
                last_cmd_ms = rq.now_ms;
                complete_flag = 1'b0;
                timeout_flag = 1'b0;
                seq_phase = cfg_mode ? cms_pkg::PH_RAMP : cms_pkg::PH_CHECK;
                starts_seen++;
            end
            cms_pkg::OP_CLEAR: begin
                entry_pending = 1'b1;
                complete_flag = 1'b0;
                timeout_flag = 1'b0;
            end
            cms_pkg::OP_POLL: begin
                case (seq_phase)
                    cms_pkg::PH_CHECK: begin
                        entry_pending = 1'b0;
                        if (el > cms_pkg::CHECK_WAIT_MS) begin
                            seq_phase = cms_pkg::PH_TRAVEL;
                            phase_start_ms = rq.now_ms;
                            entry_pending = 1'b1;
                        end
                    end
                    cms_pkg::PH_TRAVEL: begin
                        if (entry_pending) begin
                            burst.push_back(make_cmd(cms_pkg::CMD_LIMITS, {1'b0, cfg_vlim},
                                                     cfg_cur_init));
                            entry_pending = 1'b0;
                        end
                        if (rq.now_ms - last_cmd_ms >= cfg_gap) begin
                            burst.push_back(make_cmd(cms_pkg::CMD_VEL, {1'b0, cfg_speed}, '0));
                            last_cmd_ms = rq.now_ms;
                        end
                        if (el > cms_pkg::SETTLE_MS &&
                            (vmag < 17'(cms_pkg::CONTACT_SPEED) || rq.axis_error)) begin
                            burst.push_back(make_cmd(cms_pkg::CMD_VEL, '0, '0));
                            burst.push_back(make_cmd(cms_pkg::CMD_RAISE, '0, cfg_cur_cont));
                            last_cmd_ms = rq.now_ms;
                            seq_phase = cms_pkg::PH_RAMP;
                            phase_start_ms = rq.now_ms;
                            entry_pending = 1'b1;
                        end else if (el > cfg_travel_to) begin
                            timeout_flag = 1'b1;
                            complete_flag = 1'b1;
                            burst.push_back(make_cmd(cms_pkg::CMD_VEL, '0, '0));
                            last_cmd_ms = rq.now_ms;
                            seq_phase = cms_pkg::PH_DONE;
                            entry_pending = 1'b1;
                            fin = 1'b1;
                        end
                    end
                    cms_pkg::PH_RAMP: begin
                        if (entry_pending) begin
                            if (cfg_mode)
                                burst.push_back(make_cmd(cms_pkg::CMD_LIMITS,
                                                         {1'b0, cfg_vlim}, cfg_cur_init));
                            entry_pending = 1'b0;
                        end
                        target = (el >= cms_pkg::RAMP_MS)
                                 ? 64'(cfg_hold)
                                 : (64'(cfg_hold) * 64'(el)) / cms_pkg::RAMP_MS;
                        if (rq.now_ms - last_cmd_ms >= cfg_gap) begin
                            burst.push_back(make_cmd(cms_pkg::CMD_TORQUE, target[15:0], '0));
                            last_cmd_ms = rq.now_ms;
                        end
                        if ((target >= cfg_hold && el > cms_pkg::SETTLE_MS) ||
                            (el > cms_pkg::SETTLE_MS && rq.axis_error) ||
                            el > cms_pkg::RAMP_TIMEOUT_MS) begin
                            burst.push_back(make_cmd(cms_pkg::CMD_TORQUE, '0, '0));
                            last_cmd_ms = rq.now_ms;
                            complete_flag = 1'b1;
                            seq_phase = cms_pkg::PH_DONE;
                            entry_pending = 1'b1;
                            fin = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        if (burst.size() == 0)
            burst.push_back(make_cmd(cms_pkg::CMD_NONE, '0, '0));
        foreach (burst[k]) begin
            one = burst[k];
            one.finished = fin;
            one.timed_out = timeout_flag;
            one.complete_ok = complete_flag && !timeout_flag;
            one.last = (k == burst.size() - 1);
            expected_results.push_back(one);
        end
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                advance_sequencer(on_wire);
                reqs_taken++;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct &&
                    !(pending_reqs[0].drain && expected_results.size() != 0)) begin
                    on_wire = pending_reqs.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.operation  <= on_wire.op;
                    req_ch.now_ms     <= on_wire.now_ms;
                    req_ch.velocity   <= on_wire.velocity;
                    req_ch.axis_error <= on_wire.axis_error;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    function automatic void report_field(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            // cap the log on a badly broken block
            if (mismatches <= MAX_REPORTS)
                $display("%0t: result %0d %s expected %0h actual %0h",
                         $time, results_checked, name, want, got);
        end
    endfunction

    // result monitor
    always @(posedge i_clk) begin : res_monitor
        t_motor_res want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none actual command %0d",
                             $time, res_ch.command);
                end else begin
                    want = expected_results.pop_front();
                    report_field("command", 16'(want.cmd), 16'(res_ch.command));
                    report_field("value_a", want.value_a, res_ch.value_a);
                    report_field("value_b", want.value_b, res_ch.value_b);
                    report_field("finished", 16'(want.finished), 16'(res_ch.finished));
                    report_field("timed_out", 16'(want.timed_out), 16'(res_ch.timed_out));
                    report_field("complete_ok", 16'(want.complete_ok),
                                 16'(res_ch.complete_ok));
                    report_field("last", 16'(want.last), 16'(res_ch.last));
                    if (want.finished && want.last) begin
                        runs_ended++;
                        if (want.timed_out)
                            timeouts_seen++;
                    end
                end
                results_checked++;
            end
            res_ch.ready <= $urandom_range(99, 0) >= receiver_stall_pct;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAIL compression_motor_sequencer_unit");
            $finish;
        end
    end

    task automatic write_setting(input cms_pkg::t_cfg_idx idx, input logic [15:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            cms_pkg::CFG_MODE:      cfg_mode      = val[0];
            cms_pkg::CFG_GAP:       cfg_gap       = val[9:0];
            cms_pkg::CFG_SPEED:     cfg_speed     = val[14:0];
            cms_pkg::CFG_HOLD:      cfg_hold      = val[14:0];
            cms_pkg::CFG_TRAVEL_TO: cfg_travel_to = val;
            cms_pkg::CFG_VLIM:      cfg_vlim      = val[14:0];
            cms_pkg::CFG_CUR_INIT:  cfg_cur_init  = val;
            default:                cfg_cur_cont  = val;
        endcase
    endtask

    task automatic apply_settings(input logic mode, input int gap, input int speed,
                                  input int hold, input int travel_to, input int vlim,
                                  input int cur_init, input int cur_cont);
        write_setting(cms_pkg::CFG_MODE, 16'(mode));
        write_setting(cms_pkg::CFG_GAP, 16'(gap));
        write_setting(cms_pkg::CFG_SPEED, 16'(speed));
        write_setting(cms_pkg::CFG_HOLD, 16'(hold));
        write_setting(cms_pkg::CFG_TRAVEL_TO, 16'(travel_to));
        write_setting(cms_pkg::CFG_VLIM, 16'(vlim));
        write_setting(cms_pkg::CFG_CUR_INIT, 16'(cur_init));
        write_setting(cms_pkg::CFG_CUR_CONT, 16'(cur_cont));
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_random_settings(input logic mode);
        apply_settings(mode, $urandom_range(1000, 0), $urandom_range(32767, 0),
                       $urandom_range(32767, 0),
                       ($urandom_range(3, 0) == 0) ? $urandom_range(65535, 0)
                                                   : $urandom_range(3000, 0),
                       $urandom_range(32767, 0), $urandom_range(65535, 0),
                       $urandom_range(65535, 0));
    endtask

    task automatic push_req(input cms_pkg::t_op op, input logic [31:0] now_ms,
                            input logic signed [15:0] velocity, input logic axis_error,
                            input bit drain);
        t_motor_req rq;
        rq = '{op: op, now_ms: now_ms, velocity: velocity, axis_error: axis_error,
               drain: drain};
        pending_reqs.push_back(rq);
        reqs_queued++;
    endtask

    function automatic logic signed [15:0] rand_velocity();
        int v;
        if ($urandom_range(99, 0) < 30) begin
            v = int'($urandom_range(254, 0)) - 127;
            return 16'(v);
        end
        return 16'($urandom());
    endfunction

    function automatic logic [31:0] poll_step();
        int r;
        r = $urandom_range(99, 0);
        if (r < 70)
            return $urandom_range(150, 0);
        if (r < 90)
            return $urandom_range(1200, 150);
        return $urandom_range(20000, 1200);
    endfunction

    task automatic queue_directed();
        logic [31:0] t;
        push_req(cms_pkg::OP_NONE, 32'd0, 16'sd0, 1'b0, 1'b0);
        push_req(cms_pkg::OP_POLL, 32'hFFFF_FFFF, -16'sd1, 1'b1, 1'b0);
        push_req(cms_pkg::OP_CLEAR, 32'd0, 16'sd0, 1'b0, 1'b0);
        // full run across the time wrap
        t = 32'hFFFF_FF00;
        push_req(cms_pkg::OP_START, t, 16'sd0, 1'b0, 1'b1);
        push_req(cms_pkg::OP_POLL, t, 16'sd0, 1'b0, 1'b0);
        t += 51;
        push_req(cms_pkg::OP_POLL, t, 16'sh7FFF, 1'b0, 1'b0);
        push_req(cms_pkg::OP_POLL, t, 16'sh7FFF, 1'b0, 1'b0);
        t += 600;
        push_req(cms_pkg::OP_POLL, t, 16'sh8000, 1'b0, 1'b0);
        t += 20;
        push_req(cms_pkg::OP_POLL, t, 16'sd127, 1'b0, 1'b0);
        t += 1000;
        push_req(cms_pkg::OP_POLL, t, 16'sd0, 1'b0, 1'b0);
        t += 1000;
        push_req(cms_pkg::OP_POLL, t, 16'sd0, 1'b0, 1'b0);
        // entry, move, stop and raise in one poll; ramp ended by axis error
        t += 7;
        push_req(cms_pkg::OP_START, t, 16'sd0, 1'b0, 1'b0);
        t += 51;
        push_req(cms_pkg::OP_POLL, t, 16'sd0, 1'b0, 1'b0);
        t += 501;
        push_req(cms_pkg::OP_POLL, t, -16'sd127, 1'b0, 1'b0);
        t += 501;
        push_req(cms_pkg::OP_POLL, t, 16'sd3000, 1'b1, 1'b0);
        // travel timeout then clear
        push_req(cms_pkg::OP_START, t, 16'sd0, 1'b0, 1'b0);
        t += 51;
        push_req(cms_pkg::OP_POLL, t, 16'sd200, 1'b0, 1'b0);
        t += 10001;
        push_req(cms_pkg::OP_POLL, t, 16'sd200, 1'b0, 1'b0);
        push_req(cms_pkg::OP_CLEAR, t, 16'sd0, 1'b0, 1'b1);
        // clear mid-travel re-arms entry; contact by axis error
        push_req(cms_pkg::OP_START, t, 16'sd0, 1'b0, 1'b0);
        t += 51;
        push_req(cms_pkg::OP_POLL, t, 16'sd1000, 1'b0, 1'b0);
        t += 5;
        push_req(cms_pkg::OP_POLL, t, 16'sd1000, 1'b0, 1'b0);
        push_req(cms_pkg::OP_CLEAR, t, 16'sd0, 1'b0, 1'b0);
        t += 3;
        push_req(cms_pkg::OP_POLL, t, 16'sd1000, 1'b0, 1'b0);
        t += 600;
        push_req(cms_pkg::OP_POLL, t, 16'sd1000, 1'b1, 1'b0);
    endtask

    task automatic queue_random_traffic(input int n_items);
        int          added;
        int          polls;
        int          r;
        logic [31:0] clock_ms;
        added = 0;
        while (added < n_items) begin
            if ($urandom_range(99, 0) < 85) begin
                clock_ms = ($urandom_range(9, 0) == 0)
                           ? 32'hFFFF_FFFF - $urandom_range(3000, 0)
                           : $urandom();
                push_req(cms_pkg::OP_START, clock_ms, rand_velocity(), 1'b0,
                         $urandom_range(9, 0) == 0);
                added++;
                polls = $urandom_range(40, 5);
                for (int i = 0; i < polls && added < n_items; i++) begin
                    clock_ms += poll_step();
                    r = $urandom_range(99, 0);
                    if (r < 3) begin
                        push_req(cms_pkg::OP_CLEAR, clock_ms, rand_velocity(),
                                 1'($urandom()), 1'b0);
                        added++;
                    end else if (r < 5) begin
                        push_req(cms_pkg::OP_NONE, clock_ms, rand_velocity(),
                                 1'($urandom()), 1'b0);
                    end else if (r < 6) begin
                        push_req(cms_pkg::OP_START, clock_ms, rand_velocity(),
                                 1'($urandom()), 1'b0);
                        added++;
                    end else begin
                        push_req(cms_pkg::OP_POLL, clock_ms, rand_velocity(),
                                 $urandom_range(99, 0) < 4, 1'b0);
                        added++;
                    end
                end
            end else begin
                r = $urandom_range(3, 0);
                push_req(cms_pkg::t_op'(r), $urandom(), 16'($urandom()), 1'($urandom()), 1'b0);
                if (cms_pkg::t_op'(r) != cms_pkg::OP_NONE)
                    added++;
            end
        end
    endtask

    task automatic wait_quiet();
        while (pending_reqs.size() != 0 || reqs_taken != reqs_queued ||
               expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input int sender_pct, input int receiver_pct, input int n_items);
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = receiver_pct;
        queue_random_traffic(n_items);
        wait_quiet();
    endtask

    initial begin
        i_rst_n             = 1'b0;
        cfg_we              = 1'b0;
        cfg_idx             = '0;
        cfg_data            = '0;
        req_ch.valid        = 1'b0;
        req_ch.operation    = '0;
        req_ch.now_ms       = '0;
        req_ch.velocity     = '0;
        req_ch.axis_error   = 1'b0;
        res_ch.ready        = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_directed();
        run_phase(0, 0, 40);
        apply_settings(1'b0, 0, 0, 0, 0, 0, 0, 0);
        run_phase(84, 0, 65);
        apply_settings(1'b1, 1000, 32767, 32767, 65535, 32767, 65535, 65535);
        run_phase(0, 84, 65);
        apply_random_settings(1'b0);
        run_phase(16, 16, 65);
        apply_random_settings(1'($urandom()));
        run_phase(0, 0, 65);
        apply_settings(1'b0, 1000, 32767, 32767, $urandom_range(2000, 0), 32767, 65535, 65535);
        run_phase(84, 0, 65);
        apply_random_settings(1'b1);
        run_phase(0, 84, 65);
        apply_random_settings(1'b0);
        run_phase(16, 16, 65);

        $display("Covered %0d requests (%0d starts), %0d results checked;",
                 reqs_taken, starts_seen, results_checked);
        $display("%0d runs ended, %0d by travel timeout, over eight register setups %s",
                 runs_ended, timeouts_seen, "under free flow and back-pressure.");
        if (mismatches == 0) begin
            $display("PASS compression_motor_sequencer_unit");
        end else begin
            $display("FAIL compression_motor_sequencer_unit");
        end
        $finish;
    end

endmodule
